### rtl/nps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types, widths and codes for the non-preemptive priority scheduler.
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int ID_W     = 8;
    localparam int BURST_W  = 16;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 3;
    localparam int RCOUNT_W = 5;

    // command codes
    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_BURST = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RAN        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IDLE       = 3'd4;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic arrive;      // append / reject an arriving job
        logic tick_direct; // run current job or report idle
        logic scan_init;   // load entry 0 as best candidate
        logic scan_step;   // compare one more entry
        logic take_run;    // remove best, make it current, run one unit
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic proc_busy;
        logic table_empty;
        logic scan_last;
    } t_dp_stat;

endpackage

### rtl/nonpreemptive_priority_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler
// Non-preemptive priority scheduler: arrive commands fill a ready table,
// tick commands pick the most urgent job when idle and run it one unit.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+---------------------
//  command  | i_command i_job_id i_burst_length         | start && !busy
//           | i_job_priority                            |
//  result   | o_status o_running_id o_job_done          | o_valid, one cycle
//           | o_ready_count                             |
//
//  Arrive, and a tick while a job is current or the table is empty: result
//  in the next cycle after the transfer. A tick that selects a job first scans
//  the table (N jobs waiting, up to 16), comparing one table entry per cycle.
//  busy is high during the scan. Reset clears the table count and current
//  job; the results cannot be stalled.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler
    import nps_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_command,
    input  logic [ID_W-1:0]     i_job_id,
    input  logic [BURST_W-1:0]  i_burst_length,
    input  logic [PRIO_W-1:0]   i_job_priority,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [ID_W-1:0]     o_running_id,
    output logic                o_job_done,
    output logic [RCOUNT_W-1:0] o_ready_count
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    nps_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_command),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd),
        .busy      (busy)
    );

    nps_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_job_id       (i_job_id),
        .i_burst_length (i_burst_length),
        .i_job_priority (i_job_priority),
        .o_stat         (dp_stat),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_running_id   (o_running_id),
        .o_job_done     (o_job_done),
        .o_ready_count  (o_ready_count)
    );

endmodule

### rtl/nps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_ctrl
// Controller: accepts commands and sequences the ready-table scan.
// ----------------------------------------------------------------------------
module nps_ctrl
    import nps_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  logic     i_command,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_command == CMD_ARRIVE) begin
                        o_cmd.arrive = 1'b1;
                    end else if (i_stat.proc_busy || i_stat.table_empty) begin
                        o_cmd.tick_direct = 1'b1;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                busy = 1'b1;
                if (i_stat.scan_last) begin
                    o_cmd.take_run = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/nps_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_dp
// Datapath: ready table, current job, best-candidate scan and result registers.
// ----------------------------------------------------------------------------
module nps_dp
    import nps_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [ID_W-1:0]     i_job_id,
    input  logic [BURST_W-1:0]  i_burst_length,
    input  logic [PRIO_W-1:0]   i_job_priority,
    output t_dp_stat            o_stat,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [ID_W-1:0]     o_running_id,
    output logic                o_job_done,
    output logic [RCOUNT_W-1:0] o_ready_count
);

    // ready table, arrival order, entries below r_count are live
    logic [ID_W-1:0]    r_ids  [QUEUE_DEPTH];
    logic [BURST_W-1:0] r_rem  [QUEUE_DEPTH];
    logic [PRIO_W-1:0]  r_prio [QUEUE_DEPTH];

    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_run, n_run;
    logic [ID_W-1:0]    r_cur_id, n_cur_id;
    logic [BURST_W-1:0] r_cur_rem, n_cur_rem;

    logic [CNT_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_best_slot;
    logic [PRIO_W-1:0]  r_best_prio;
    logic [ID_W-1:0]    r_best_id;
    logic [BURST_W-1:0] r_best_rem;

    logic                r_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [ID_W-1:0]     r_run_id, n_run_id;
    logic                r_done, n_done;
    logic [RCOUNT_W-1:0] r_rcount;

    logic               append;
    logic [IDX_W-1:0]   scan_addr;
    logic               better;
    logic [ID_W-1:0]    sel_id;
    logic [BURST_W-1:0] sel_rem;
    logic [BURST_W-1:0] dec_rem;

    assign o_stat.proc_busy   = r_run;
    assign o_stat.table_empty = (r_count == '0);
    assign o_stat.scan_last   = (r_idx == r_count);

    assign scan_addr = r_idx[IDX_W-1:0];
    assign better    = (r_prio[scan_addr] < r_best_prio);

    assign sel_id  = i_cmd.take_run ? r_best_id  : r_cur_id;
    assign sel_rem = i_cmd.take_run ? r_best_rem : r_cur_rem;
    assign dec_rem = (sel_rem != '0) ? sel_rem - 1'b1 : sel_rem;

    always_comb begin
        append    = 1'b0;
        n_count   = r_count;
        n_run     = r_run;
        n_cur_id  = r_cur_id;
        n_cur_rem = r_cur_rem;
        n_status  = ST_IDLE;
        n_run_id  = '0;
        n_done    = 1'b0;
        if (i_cmd.arrive) begin
            if (r_count >= CNT_W'(QUEUE_DEPTH)) begin
                n_status = ST_FULL;
            end else if (i_burst_length == '0) begin
                n_status = ST_ZERO_BURST;
            end else begin
                append   = 1'b1;
                n_count  = r_count + 1'b1;
                n_status = ST_ACCEPTED;
            end
        end else if ((i_cmd.tick_direct && r_run) || i_cmd.take_run) begin
            if (i_cmd.take_run) begin
                n_count = r_count - 1'b1;
            end
            n_status  = ST_RAN;
            n_run_id  = sel_id;
            n_cur_id  = sel_id;
            n_cur_rem = dec_rem;
            n_done    = (dec_rem == '0);
            n_run     = (dec_rem != '0);
        end
    end

    // table update: shift up behind the removed slot, or append at the tail
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (i_cmd.take_run && (IDX_W'(k) >= r_best_slot) && (k < QUEUE_DEPTH - 1)) begin
                r_ids[k]  <= r_ids[(k + 1) % QUEUE_DEPTH];
                r_rem[k]  <= r_rem[(k + 1) % QUEUE_DEPTH];
                r_prio[k] <= r_prio[(k + 1) % QUEUE_DEPTH];
            end else if (append && (CNT_W'(k) == r_count)) begin
                r_ids[k]  <= i_job_id;
                r_rem[k]  <= i_burst_length;
                r_prio[k] <= i_job_priority;
            end
        end
    end

    // best-candidate scan, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_idx       <= CNT_W'(1);
            r_best_slot <= '0;
            r_best_prio <= r_prio[0];
            r_best_id   <= r_ids[0];
            r_best_rem  <= r_rem[0];
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + 1'b1;
            if (better) begin
                r_best_slot <= scan_addr;
                r_best_prio <= r_prio[scan_addr];
                r_best_id   <= r_ids[scan_addr];
                r_best_rem  <= r_rem[scan_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_run     <= 1'b0;
            r_cur_id  <= '0;
            r_cur_rem <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_run     <= n_run;
            r_cur_id  <= n_cur_id;
            r_cur_rem <= n_cur_rem;
            r_valid   <= i_cmd.arrive | i_cmd.tick_direct | i_cmd.take_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.arrive || i_cmd.tick_direct || i_cmd.take_run) begin
            r_status <= n_status;
            r_run_id <= n_run_id;
            r_done   <= n_done;
            r_rcount <= RCOUNT_W'(n_count);
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_running_id  = r_run_id;
    assign o_job_done    = r_done;
    assign o_ready_count = r_rcount;

endmodule

### rtl/nps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_checker
// Port-level assertions for the priority scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module nps_checker
    import nps_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                i_command,
    input logic                o_valid,
    input logic [STATUS_W-1:0] o_status,
    input logic [ID_W-1:0]     o_running_id,
    input logic                o_job_done
);

    // an arrive transfer is answered in the next cycle
    a_arrive_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == CMD_ARRIVE)) |=> o_valid)
        else $error("arrive result missing");

    // no result is shown while the scan is in progress
    a_quiet_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_valid)
        else $error("result during scan");

    // only a run result carries a job id or a done flag
    a_non_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_RAN)) |-> ((o_running_id == '0) && !o_job_done))
        else $error("non-run result carries job data");

    // a scan always ends with a run result
    a_scan_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_valid && (o_status == ST_RAN)))
        else $error("scan did not end in a run");

endmodule

bind nonpreemptive_priority_scheduler nps_checker u_nps_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_command    (i_command),
    .o_valid      (o_valid),
    .o_status     (o_status),
    .o_running_id (o_running_id),
    .o_job_done   (o_job_done)
);
